[design/b64u_pkg.sv]
// b64u_pkg: shared types, register indexes and the URL-safe alphabet lookup
// for the base64url stream encoder. No dependencies.
package b64u_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h2E;   // '.'
   localparam int unsigned MAX_CHARS = 4;

   // configuration register indexes
   localparam logic CSR_PADDING_ENABLE = 1'b0;
   localparam logic CSR_OUTPUT_LIMIT   = 1'b1;

   // per-transfer encoding result, step logic -> top level
   typedef struct packed {
      logic [3:0][7:0] chars;          // slot 0 leaves first
      logic [2:0]      count;          // characters kept after the limit, 0..4
      logic [15:0]     first_sent;     // chars_sent value of slot 0
      logic [1:0]      phase;          // next group position
      logic [5:0]      leftover;       // next pending bits
      logic [15:0]     emitted;        // next per-message character count
   } step_result_type;

   // 6-bit index to URL-safe alphabet character
   function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
      logic [7:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26)       alphabet_char = 8'(8'd65 + wide);           // A-Z
      else if (idx < 6'd52)  alphabet_char = 8'(8'd97 + wide - 8'd26);   // a-z
      else if (idx < 6'd62)  alphabet_char = 8'(8'd48 + wide - 8'd52);   // 0-9
      else if (idx == 6'd62) alphabet_char = 8'h2D;                      // '-'
      else                   alphabet_char = 8'h5F;                      // '_'
   endfunction

endpackage

[design/b64u_step.sv]
// b64u_step: combinational encoding of one input byte into up to four
// characters, with flush, padding and limit handling. Uses b64u_pkg.
module b64u_step (
   input  logic [7:0]               data_byte,
   input  logic                     end_of_message,
   input  logic [1:0]               phase,
   input  logic [5:0]               leftover,
   input  logic [15:0]              emitted,
   input  logic                     padding_enable,
   input  logic [15:0]              output_limit,
   output b64u_pkg::step_result_type result
);

   logic [3:0][7:0] chars;
   logic [2:0]      cand;
   logic [1:0]      nphase;
   logic [5:0]      nleft;
   logic [15:0]     avail;
   logic [2:0]      kept;

   always_comb begin
      chars  = {4{b64u_pkg::PAD_CHAR}};
      cand   = 3'd1;
      nphase = 2'd1;
      nleft  = 6'd0;
      case (phase)
         2'd1: begin
            chars[0] = b64u_pkg::alphabet_char(leftover | {2'b00, data_byte[7:4]});
            nleft    = {data_byte[3:0], 2'b00};
            nphase   = 2'd2;
         end
         2'd2: begin
            chars[0] = b64u_pkg::alphabet_char(leftover | {4'b0000, data_byte[7:6]});
            chars[1] = b64u_pkg::alphabet_char(data_byte[5:0]);
            cand     = 3'd2;
            nleft    = 6'd0;
            nphase   = 2'd0;
         end
         default: begin   // group start; the unused code acts the same
            chars[0] = b64u_pkg::alphabet_char(data_byte[7:2]);
            nleft    = {data_byte[1:0], 4'b0000};
            nphase   = 2'd1;
         end
      endcase

      // flush only happens after a one-slot byte, so extras go in slots 1..3
      if (end_of_message && nphase != 2'd0) begin
         chars[1] = b64u_pkg::alphabet_char(nleft);
         if (padding_enable) cand = (nphase == 2'd1) ? 3'd4 : 3'd3;
         else                cand = 3'd2;
      end

      // characters past the limit are tail-dropped
      avail = (emitted < output_limit) ? 16'(output_limit - emitted) : 16'd0;
      kept  = (avail < {13'd0, cand}) ? avail[2:0] : cand;

      result.chars      = chars;
      result.count      = kept;
      result.first_sent = 16'(emitted + 16'd1);
      result.phase      = end_of_message ? 2'd0 : nphase;
      result.leftover   = end_of_message ? 6'd0 : nleft;
      result.emitted    = end_of_message ? 16'd0 : 16'(emitted + {13'd0, kept});
   end

endmodule

[design/base64url_stream_encoder.sv]
// base64url_stream_encoder: top level; byte stream in, URL-safe base64
// characters out. Uses b64u_pkg and b64u_step.
// Latency: first character of a transfer is presented the cycle after it.
// Throughput: a new input transfer enters when the buffer is empty or as its
//   last character leaves, so the single-character output port sets the pace.
// Reset (synchronous): padding on, limit 65535, encoder state and buffer cleared.
module base64url_stream_encoder (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_run_last,
   output logic [15:0] rsp_chars_sent,
   // configuration
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   // configuration registers
   logic        pad_en_ff;
   logic [15:0] limit_ff;

   // encoder state carried between bytes
   logic [1:0]  phase_ff,   phase_in;
   logic [5:0]  left_ff,    left_in;
   logic [15:0] emitted_ff, emitted_in;

   // burst buffer: characters of one transfer, slot 0 is on the port
   logic [3:0][7:0] chars_ff, chars_in;
   logic [2:0]      rem_ff,   rem_in;
   logic [15:0]     sent_ff,  sent_in;

   b64u_pkg::step_result_type step;

   logic take;
   logic last_take;
   logic accept;

   b64u_step u_step (
      .data_byte      (req_data_byte),
      .end_of_message (req_end_of_message),
      .phase          (phase_ff),
      .leftover       (left_ff),
      .emitted        (emitted_ff),
      .padding_enable (pad_en_ff),
      .output_limit   (limit_ff),
      .result         (step)
   );

   // handshakes: a new byte may enter as the last buffered character leaves
   assign rsp_valid = (rem_ff != 3'd0);
   assign take      = rsp_valid && !rsp_stall;
   assign last_take = take && (rem_ff == 3'd1);
   assign req_stall = rsp_valid && !last_take;
   assign accept    = req_valid && !req_stall;

   assign rsp_out_char   = chars_ff[0];
   assign rsp_run_last   = (rem_ff == 3'd1);
   assign rsp_chars_sent = sent_ff;

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      emitted_in = emitted_ff;
      chars_in   = chars_ff;
      rem_in     = rem_ff;
      sent_in    = sent_ff;
      if (take) begin
         chars_in = {8'h00, chars_ff[3:1]};
         rem_in   = 3'(rem_ff - 3'd1);
         sent_in  = 16'(sent_ff + 16'd1);
      end
      if (accept) begin
         phase_in   = step.phase;
         left_in    = step.leftover;
         emitted_in = step.emitted;
         // a transfer with every character dropped leaves the buffer empty
         if (step.count != 3'd0) begin
            chars_in = step.chars;
            rem_in   = step.count;
            sent_in  = step.first_sent;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_en_ff  <= 1'b1;
         limit_ff   <= 16'hFFFF;
         phase_ff   <= 2'd0;
         left_ff    <= 6'd0;
         emitted_ff <= 16'd0;
         rem_ff     <= 3'd0;
      end else begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         emitted_ff <= emitted_in;
         rem_ff     <= rem_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               b64u_pkg::CSR_PADDING_ENABLE: pad_en_ff <= csr_write_data[0];
               b64u_pkg::CSR_OUTPUT_LIMIT:   limit_ff  <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      sent_ff  <= sent_in;
   end

   // while the buffer holds characters, a transfer only enters as it drains its final one
   a_accept_on_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid) |-> (!rsp_stall && rsp_run_last))
      else $error("input accepted while burst buffer still holds characters");

   // mid-burst characters keep counting up by one
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_run_last) |=> (rsp_valid && rsp_chars_sent == 16'($past(rsp_chars_sent) + 16'd1)))
      else $error("chars_sent did not advance within a burst");

   // burst never exceeds four characters
   a_burst_len: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'(b64u_pkg::MAX_CHARS))
      else $error("burst buffer overfilled");

endmodule

[bench/tb_base64url_stream_encoder.sv]
// Self-checking bench for base64url_stream_encoder: drives byte messages, predicts
// the URL-safe characters, pads and running counts, and compares each result transfer.
// Depends on b64u_pkg (register indexes, pad character) and the encoder RTL.
module tb_base64url_stream_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   // generous watchdog: ~425 bytes, up to 4 chars each, long receiver stalls
   localparam int CYCLE_LIMIT = 300000;
   // idle time before a register write or the end check; covers in-flight bursts
   localparam int SETTLE_CYCLES = 16;

   // directed messages under reset settings: 1, 2, 3, 4 and 5 byte messages,
   // all-zero, all-one, the '-' and '_' corners of the alphabet
   localparam int DIR_COUNT = 15;
   localparam logic [7:0] DIR_BYTES [DIR_COUNT] = '{
      8'h00,
      8'hFF, 8'hFF,
      8'hFB, 8'hEF, 8'hBE,
      8'hFF, 8'hFF, 8'hFF, 8'h00,
      8'h4D, 8'h61, 8'h6E, 8'h80, 8'h7F
   };
   localparam logic DIR_EOM [DIR_COUNT] = '{
      1'b1,
      1'b0, 1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1
   };

   // ------------------------------------------------------------------
   // Scoreboard: predicts the characters each accepted byte yields and
   // checks result transfers against them in order.
   // ------------------------------------------------------------------
   class b64_scoreboard;
      typedef struct {
         bit [7:0]  ch;
         bit        last;
         bit [15:0] sent;
      } char_rec_type;

      bit        pad_on;
      bit [15:0] char_limit;
      bit [1:0]  grp_pos;       // position in the 3-byte group
      bit [5:0]  carry_bits;    // pending bits, already aligned to a 6-bit index
      bit [15:0] msg_chars;     // characters emitted in the current message
      char_rec_type expected_chars[$];
      char_rec_type burst[$];
      int        fails;
      int        bytes_seen;
      int        msgs_seen;
      int        chars_checked;
      int        chars_dropped;

      function new();
         pad_on        = 1'b1;
         char_limit    = 16'hFFFF;
         grp_pos       = 2'd0;
         carry_bits    = 6'd0;
         msg_chars     = 16'd0;
         fails         = 0;
         bytes_seen    = 0;
         msgs_seen     = 0;
         chars_checked = 0;
         chars_dropped = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] value);
         if (idx == b64u_pkg::CSR_PADDING_ENABLE) begin
            pad_on = value[0];
         end else begin
            char_limit = value;
         end
      endfunction

      function bit [7:0] url_char(bit [5:0] v);
         if (v < 6'd26) return 8'h41 + {2'b00, v};
         if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
         if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
         if (v == 6'd62) return 8'h2D;
         return 8'h5F;
      endfunction

      // keep a character only while the message is under its limit
      function void put(bit [7:0] c);
         char_rec_type r;
         if (msg_chars < char_limit) begin
            msg_chars = msg_chars + 16'd1;
            r.ch   = c;
            r.last = 1'b0;
            r.sent = msg_chars;
            burst.push_back(r);
         end else begin
            chars_dropped++;
         end
      endfunction

      function void note_input(bit [7:0] b, bit eom);
         burst.delete();
         bytes_seen++;
         case (grp_pos)
            2'd1: begin
               put(url_char(carry_bits | {2'b00, b[7:4]}));
               carry_bits = {b[3:0], 2'b00};
               grp_pos    = 2'd2;
            end
            2'd2: begin
               put(url_char(carry_bits | {4'b0000, b[7:6]}));
               put(url_char(b[5:0]));
               carry_bits = 6'd0;
               grp_pos    = 2'd0;
            end
            default: begin
               put(url_char(b[7:2]));
               carry_bits = {b[1:0], 4'b0000};
               grp_pos    = 2'd1;
            end
         endcase
         if (eom) begin
            if (grp_pos != 2'd0) begin
               put(url_char(carry_bits));
               if (pad_on) begin
                  put(b64u_pkg::PAD_CHAR);
                  if (grp_pos == 2'd1) put(b64u_pkg::PAD_CHAR);
               end
            end
            grp_pos    = 2'd0;
            carry_bits = 6'd0;
            msg_chars  = 16'd0;
            msgs_seen++;
         end
         if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) expected_chars.push_back(burst[i]);
      endfunction

      function void check_result(logic [7:0] ch, logic last, logic [15:0] sent);
         char_rec_type e;
         if (expected_chars.size() == 0) begin
            $error("unexpected result transfer: out_char 0x%02h, nothing pending", ch);
            fails++;
            return;
         end
         e = expected_chars.pop_front();
         chars_checked++;
         if (ch !== e.ch) begin
            $error("out_char: expected 0x%02h, actual 0x%02h", e.ch, ch);
            fails++;
         end
         if (last !== e.last) begin
            $error("run_last: expected %0b, actual %0b", e.last, last);
            fails++;
         end
         if (sent !== e.sent) begin
            $error("chars_sent: expected %0d, actual %0d", e.sent, sent);
            fails++;
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function void close_out();
         if (expected_chars.size() != 0) begin
            $error("%0d expected characters never arrived", expected_chars.size());
            fails++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT signals: every input has a known value from time zero
   // ------------------------------------------------------------------
   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_run_last;
   logic [15:0] rsp_chars_sent;
   logic        csr_write_enable   = 1'b0;
   logic        csr_index          = b64u_pkg::CSR_PADDING_ENABLE;
   logic [15:0] csr_write_data     = 16'h0000;

   b64_scoreboard sb;
   int            cycle_count = 0;
   int            burst_left  = 0;
   int            stall_mode  = 0;
   int            stall_left  = 0;

   base64url_stream_encoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_run_last       (rsp_run_last),
      .rsp_chars_sent     (rsp_chars_sent),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // Monitor: everything sampled right after the edge sees pre-edge values,
   // since both the DUT and the drivers update through nonblocking assignments.
   // A byte noted here cannot produce a character on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_input(req_data_byte, req_end_of_message);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_out_char, rsp_run_last, rsp_chars_sent);
      end
   end

   // Receiver back-pressure: modes of random length - free flowing, light
   // random stall, heavy random stall, and a toggle that lines up with the
   // character bursts in alternating phases.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still pending",
                  cycle_count, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // One input transfer. The sender runs in bursts; between bursts it may drop
   // valid for a random gap. Valid stays high across back-to-back transfers and
   // the payload holds while stalled. Returns at the edge that took the transfer.
   task automatic send_byte(input logic [7:0] b, input logic eom);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_stall);
   endtask

   // called in the step of the last transfer, so valid gets a single update
   task automatic sender_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
   endtask

   // one edge first so the monitor has noted the final byte, then wait for
   // every predicted character and let any dropped-only work settle
   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // a message of random content, extremes mixed in; ends with the marked byte
   task automatic send_message(input int len);
      logic [7:0] b;
      int         pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0)      b = 8'h00;
         else if (pick == 1) b = 8'hFF;
         else                b = 8'($urandom_range(0, 255));
         send_byte(b, i == len - 1);
      end
   endtask

   // One configuration phase: write both registers while idle, then whole
   // messages until about n_bytes bytes went in. Lengths lean short so every
   // group phase ends messages often; a few long ones cross small limits.
   task automatic run_phase(input logic pad, input logic [15:0] lim, input int n_bytes);
      int sent_bytes;
      int len;
      int pick;
      sent_bytes = 0;
      csr_write(b64u_pkg::CSR_PADDING_ENABLE, {15'd0, pad});
      csr_write(b64u_pkg::CSR_OUTPUT_LIMIT, lim);
      while (sent_bytes < n_bytes) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5)      len = $urandom_range(1, 6);
         else if (pick <= 8) len = $urandom_range(7, 15);
         else                len = $urandom_range(16, 40);
         send_message(len);
         sent_bytes += len;
      end
      sender_idle();
      wait_drained();
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings (padding on, no practical limit)
      for (int i = 0; i < DIR_COUNT; i++) send_byte(DIR_BYTES[i], DIR_EOM[i]);
      sender_idle();
      wait_drained();

      // directed: zero limit - every byte yields no transfer at all
      csr_write(b64u_pkg::CSR_OUTPUT_LIMIT, 16'd0);
      send_byte(8'h55, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h3C, 1'b1);
      sender_idle();
      wait_drained();

      // directed: limit of two cuts a full group mid-way; count restarts
      // at the next message
      csr_write(b64u_pkg::CSR_OUTPUT_LIMIT, 16'd2);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'h01, 1'b1);
      sender_idle();
      wait_drained();

      // random phases over both padding settings and the limit extremes
      run_phase(1'b0, 16'hFFFF, 60);
      run_phase(1'b1, 16'd0, 40);
      run_phase(1'b1, 16'd3, 60);
      run_phase(1'b0, 16'd1, 40);
      run_phase(1'b1, 16'($urandom_range(2, 12)), 70);
      run_phase(1'b0, 16'($urandom_range(4, 30)), 70);
      run_phase(1'b1, 16'hFFFF, 60);

      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.close_out();

      $display("Encoded %0d bytes in %0d messages; %0d characters checked, %0d cut by the limit.",
               sb.bytes_seen, sb.msgs_seen, sb.chars_checked, sb.chars_dropped);
      $display("Settings covered: padding on/off, limits 0, 1, 2, 3, random small and 65535.");
      if (sb.fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", sb.fails);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
